>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check sampled on the rising clock edge, switched off while reset is asserted
`define BPOP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// concurrent check that also runs through reset
`define BPOP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/bpop_pkg.sv
package bpop_pkg;

    // fraction bits of the rotation terms; the fine unit is 2^-(ROT_FRAC_BITS+1) lsb
    localparam int ROT_FRAC_BITS = 14;
    localparam int FINE_SHIFT    = ROT_FRAC_BITS + 1;

    localparam int COORD_W = 32;
    localparam int SIZE_W  = 31;
    localparam int ROT_W   = 16;

    localparam int PROD_W  = ROT_W + SIZE_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PEN_W   = SUM_W + 2;
    localparam int MAG_W   = PEN_W - 1;
    localparam int ROUND_W = MAG_W + 1 - FINE_SHIFT;
    localparam int SHIFT_W = 34;

    localparam int S_TDATA_W = 320;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 1;

    localparam int NUM_STAGES = 6;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [SIZE_W-1:0]         width;
        logic [SIZE_W-1:0]         height;
        logic signed [ROT_W-1:0]   cs;
        logic signed [ROT_W-1:0]   sn;
    } box_t;

    typedef struct packed {
        logic [SUM_W-1:0]         ext_x;
        logic [SUM_W-1:0]         ext_y;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
    } extent_t;

    typedef struct packed {
        logic load_prod;
        logic load_sum;
    } ext_ctrl_t;

    typedef struct packed {
        logic load_pen;
        logic load_pick;
        logic load_out;
    } sel_ctrl_t;

    // magnitude of a rotation term; the most negative code maps onto 2^(ROT_W-1)
    function automatic logic [ROT_W-1:0] rot_mag(input logic signed [ROT_W-1:0] v);
        return v[ROT_W-1] ? ROT_W'(-v) : ROT_W'(v);
    endfunction

endpackage

>>> hw/rtl/box_pair_overlap_pushout_core.sv
// box pair overlap and push-out core
// s_ channel: one request per box pair, mover then obstacle, each as centre x, y (signed
//   q16.16), full width, height (unsigned q15.16) and z rotation cos, sin (signed q1.14)
// m_ channel: one result per request, in request order; m_tuser flags a collision and
//   m_tdata carries the x and y push-out for the mover (signed q18.16), zero when there is none
// throughput: one request per cycle, sustained, as long as results are taken
// the path runs through six register stages (input, rotation products, extent sums,
//   clearances, minimum pick, rounding)
// every stage keeps its own valid bit, so bubbles close up while the receiver stalls and
//   s_tready only drops once every stage holds a request
// reset (aresetn low at a clock edge) drops all valid bits; requests in flight are lost
// and no result appears until new requests arrive
module box_pair_overlap_pushout_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // mover x, mover y, mover width, mover height, mover cos, mover sin,
    // block x, block y, block width, block height, block cos, block sin, zero pad
    input  logic [bpop_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // shift x, shift y, zero pad
    output logic [bpop_pkg::M_TDATA_W-1:0]      m_tdata,
    // overlap
    output logic [bpop_pkg::M_TUSER_W-1:0]      m_tuser
);

    localparam int NS = bpop_pkg::NUM_STAGES;

    logic [NS-1:0] vld_reg, vld_next, ld;
    bpop_pkg::box_t mover_reg, block_reg, mover_next, block_next;
    bpop_pkg::ext_ctrl_t ext_ctrl;
    bpop_pkg::sel_ctrl_t sel_ctrl;
    bpop_pkg::extent_t ext;
    logic overlap;
    logic signed [bpop_pkg::SHIFT_W-1:0] shift_x, shift_y;

    // a stage loads when it is empty or its content moves on this cycle
    always_comb begin
        ld[NS-1] = !vld_reg[NS-1] || m_tready;
        for (int i = NS - 2; i >= 0; i--) begin
            ld[i] = !vld_reg[i] || ld[i+1];
        end
        vld_next[0] = ld[0] ? s_tvalid : vld_reg[0];
        for (int i = 1; i < NS; i++) begin
            vld_next[i] = ld[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // unpack the request, lowest field first
    always_comb begin
        mover_next.x      = s_tdata[31:0];
        mover_next.y      = s_tdata[63:32];
        mover_next.width  = s_tdata[94:64];
        mover_next.height = s_tdata[125:95];
        mover_next.cs     = s_tdata[141:126];
        mover_next.sn     = s_tdata[157:142];
        block_next.x      = s_tdata[189:158];
        block_next.y      = s_tdata[221:190];
        block_next.width  = s_tdata[252:222];
        block_next.height = s_tdata[283:253];
        block_next.cs     = s_tdata[299:284];
        block_next.sn     = s_tdata[315:300];
    end

    // input register
    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            mover_reg <= mover_next;
            block_reg <= block_next;
        end
    end

    always_comb begin
        ext_ctrl.load_prod = ld[1];
        ext_ctrl.load_sum  = ld[2];
        sel_ctrl.load_pen  = ld[3];
        sel_ctrl.load_pick = ld[4];
        sel_ctrl.load_out  = ld[5];
    end

    bpop_extent u_extent (
        .aclk  (aclk),
        .ctrl  (ext_ctrl),
        .mover (mover_reg),
        .block (block_reg),
        .ext   (ext)
    );

    bpop_select u_select (
        .aclk    (aclk),
        .ctrl    (sel_ctrl),
        .ext     (ext),
        .overlap (overlap),
        .shift_x (shift_x),
        .shift_y (shift_y)
    );

    assign s_tready = ld[0];
    assign m_tvalid = vld_reg[NS-1];
    assign m_tdata  = {(bpop_pkg::M_TDATA_W - 2 * bpop_pkg::SHIFT_W)'(0), shift_y, shift_x};
    assign m_tuser  = bpop_pkg::M_TUSER_W'(overlap);

endmodule

>>> hw/rtl/bpop_extent.sv
module bpop_extent (
    input  logic                aclk,
    input  bpop_pkg::ext_ctrl_t ctrl,
    input  bpop_pkg::box_t      mover,
    input  bpop_pkg::box_t      block,
    output bpop_pkg::extent_t   ext
);

    logic [bpop_pkg::PROD_W-1:0] mcw_reg, msh_reg, msw_reg, mch_reg;
    logic [bpop_pkg::PROD_W-1:0] bcw_reg, bsh_reg, bsw_reg, bch_reg;
    logic [bpop_pkg::PROD_W-1:0] mcw_next, msh_next, msw_next, mch_next;
    logic [bpop_pkg::PROD_W-1:0] bcw_next, bsh_next, bsw_next, bch_next;
    logic signed [bpop_pkg::DIFF_W-1:0] dx_reg, dy_reg, dx_next, dy_next;
    logic [bpop_pkg::ROT_W-1:0] mc, ms, bc, bs;
    bpop_pkg::extent_t ext_reg, ext_next;

    // stage one: rotation products and centre offsets
    always_comb begin
        mc = bpop_pkg::rot_mag(mover.cs);
        ms = bpop_pkg::rot_mag(mover.sn);
        bc = bpop_pkg::rot_mag(block.cs);
        bs = bpop_pkg::rot_mag(block.sn);
        mcw_next = bpop_pkg::PROD_W'(mc) * bpop_pkg::PROD_W'(mover.width);
        msh_next = bpop_pkg::PROD_W'(ms) * bpop_pkg::PROD_W'(mover.height);
        msw_next = bpop_pkg::PROD_W'(ms) * bpop_pkg::PROD_W'(mover.width);
        mch_next = bpop_pkg::PROD_W'(mc) * bpop_pkg::PROD_W'(mover.height);
        bcw_next = bpop_pkg::PROD_W'(bc) * bpop_pkg::PROD_W'(block.width);
        bsh_next = bpop_pkg::PROD_W'(bs) * bpop_pkg::PROD_W'(block.height);
        bsw_next = bpop_pkg::PROD_W'(bs) * bpop_pkg::PROD_W'(block.width);
        bch_next = bpop_pkg::PROD_W'(bc) * bpop_pkg::PROD_W'(block.height);
        dx_next  = bpop_pkg::DIFF_W'($signed(block.x)) - bpop_pkg::DIFF_W'($signed(mover.x));
        dy_next  = bpop_pkg::DIFF_W'($signed(block.y)) - bpop_pkg::DIFF_W'($signed(mover.y));
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_prod) begin
            mcw_reg <= mcw_next;
            msh_reg <= msh_next;
            msw_reg <= msw_next;
            mch_reg <= mch_next;
            bcw_reg <= bcw_next;
            bsh_reg <= bsh_next;
            bsw_reg <= bsw_next;
            bch_reg <= bch_next;
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
        end
    end

    // stage two: combined half extents of both boxes per axis
    always_comb begin
        ext_next.ext_x = bpop_pkg::SUM_W'(mcw_reg) + bpop_pkg::SUM_W'(msh_reg)
                       + bpop_pkg::SUM_W'(bcw_reg) + bpop_pkg::SUM_W'(bsh_reg);
        ext_next.ext_y = bpop_pkg::SUM_W'(msw_reg) + bpop_pkg::SUM_W'(mch_reg)
                       + bpop_pkg::SUM_W'(bsw_reg) + bpop_pkg::SUM_W'(bch_reg);
        ext_next.dx    = dx_reg;
        ext_next.dy    = dy_reg;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_sum) begin
            ext_reg <= ext_next;
        end
    end

    assign ext = ext_reg;

endmodule

>>> hw/rtl/bpop_select.sv
module bpop_select (
    input  logic                                aclk,
    input  bpop_pkg::sel_ctrl_t                 ctrl,
    input  bpop_pkg::extent_t                   ext,
    output logic                                overlap,
    output logic signed [bpop_pkg::SHIFT_W-1:0] shift_x,
    output logic signed [bpop_pkg::SHIFT_W-1:0] shift_y
);

    logic signed [bpop_pkg::PEN_W-1:0] dxs, dys, ex, ey;
    logic signed [bpop_pkg::PEN_W-1:0] pen_a_reg, pen_b_reg, pen_c_reg, pen_d_reg;
    logic signed [bpop_pkg::PEN_W-1:0] pen_a_next, pen_b_next, pen_c_next, pen_d_next;
    logic hit3_reg, hit3_next;

    logic [bpop_pkg::MAG_W-1:0] ma, mb, mc, md, m01, m23;
    logic pick_b, pick_d;
    logic [bpop_pkg::MAG_W-1:0] mag_reg, mag_next;
    logic hit4_reg, use_y_reg, neg_reg, use_y_next, neg_next;

    logic [bpop_pkg::MAG_W:0] rsum;
    logic [bpop_pkg::ROUND_W-1:0] rmag;
    logic signed [bpop_pkg::SHIFT_W-1:0] sval;
    logic overlap_reg;
    logic signed [bpop_pkg::SHIFT_W-1:0] shift_x_reg, shift_y_reg, shift_x_next, shift_y_next;

    // stage three: clearances a = -pen(-x), b = pen(+x), likewise c, d on y
    always_comb begin
        dxs = $signed(bpop_pkg::PEN_W'(ext.dx)) <<< bpop_pkg::FINE_SHIFT;
        dys = $signed(bpop_pkg::PEN_W'(ext.dy)) <<< bpop_pkg::FINE_SHIFT;
        ex  = $signed({2'b00, ext.ext_x});
        ey  = $signed({2'b00, ext.ext_y});
        pen_a_next = ex - dxs;
        pen_b_next = ex + dxs;
        pen_c_next = ey - dys;
        pen_d_next = ey + dys;
        // touching is a hit, so only a negative clearance separates the boxes
        hit3_next  = !pen_a_next[bpop_pkg::PEN_W-1] && !pen_b_next[bpop_pkg::PEN_W-1]
                  && !pen_c_next[bpop_pkg::PEN_W-1] && !pen_d_next[bpop_pkg::PEN_W-1];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_pen) begin
            pen_a_reg <= pen_a_next;
            pen_b_reg <= pen_b_next;
            pen_c_reg <= pen_c_next;
            pen_d_reg <= pen_d_next;
            hit3_reg  <= hit3_next;
        end
    end

    // stage four: first smallest magnitude, earlier candidate wins a tie
    always_comb begin
        ma = pen_a_reg[bpop_pkg::MAG_W-1:0];
        mb = pen_b_reg[bpop_pkg::MAG_W-1:0];
        mc = pen_c_reg[bpop_pkg::MAG_W-1:0];
        md = pen_d_reg[bpop_pkg::MAG_W-1:0];
        pick_b = mb < ma;
        pick_d = md < mc;
        m01 = pick_b ? mb : ma;
        m23 = pick_d ? md : mc;
        use_y_next = m23 < m01;
        mag_next   = use_y_next ? m23 : m01;
        neg_next   = use_y_next ? !pick_d : !pick_b;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_pick) begin
            mag_reg   <= mag_next;
            use_y_reg <= use_y_next;
            neg_reg   <= neg_next;
            hit4_reg  <= hit3_reg;
        end
    end

    // stage five: round to nearest, ties away from zero, then restore the sign
    always_comb begin
        rsum = {1'b0, mag_reg} + (bpop_pkg::MAG_W+1)'(1 << bpop_pkg::ROT_FRAC_BITS);
        rmag = rsum[bpop_pkg::MAG_W:bpop_pkg::FINE_SHIFT];
        sval = neg_reg ? -bpop_pkg::SHIFT_W'(rmag) : bpop_pkg::SHIFT_W'(rmag);
        shift_x_next = (hit4_reg && !use_y_reg) ? sval : '0;
        shift_y_next = (hit4_reg && use_y_reg) ? sval : '0;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_out) begin
            overlap_reg <= hit4_reg;
            shift_x_reg <= shift_x_next;
            shift_y_reg <= shift_y_next;
        end
    end

    assign overlap = overlap_reg;
    assign shift_x = shift_x_reg;
    assign shift_y = shift_y_reg;

endmodule

>>> hw/rtl/bpop_checker.sv
`include "assert_macros.svh"

module bpop_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [bpop_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [bpop_pkg::M_TUSER_W-1:0] m_tuser
);

    // a stalled result stays put
    `BPOP_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // no collision means no shift at all
    `BPOP_ASSERT(a_miss_zero, aclk, aresetn, m_tvalid && !m_tuser[0] |-> m_tdata == '0, "shift reported without a collision")

    // the push-out lies on one axis only
    `BPOP_ASSERT(a_one_axis, aclk, aresetn, m_tvalid |-> m_tdata[bpop_pkg::SHIFT_W-1:0] == '0 || m_tdata[2*bpop_pkg::SHIFT_W-1:bpop_pkg::SHIFT_W] == '0, "shift on both axes")

    // reset empties the pipeline
    `BPOP_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid straight after reset")

endmodule

bind box_pair_overlap_pushout_core bpop_checker u_bpop_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> verif/box_pair_checker.sv
module box_pair_checker
    import bpop_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // mover x, y, width, height, cos, sin, block x, y, width, height, cos, sin, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // shift x, shift y, zero pad
    input  logic [M_TDATA_W-1:0] m_tdata,
    // overlap
    input  logic [M_TUSER_W-1:0] m_tuser,
    output int                   fail_count,
    output int                   pending_count
);

    localparam int BOX_BITS = 2*COORD_W + 2*SIZE_W + 2*ROT_W;
    localparam longint FINE_ONE = 64'sd1 <<< FINE_SHIFT;

    typedef enum int {PUSH_NEG_X, PUSH_POS_X, PUSH_NEG_Y, PUSH_POS_Y} push_dir_t;

    typedef struct {
        logic               overlap;
        logic [SHIFT_W-1:0] shift_x;
        logic [SHIFT_W-1:0] shift_y;
    } pushout_t;

    typedef struct {
        longint lo_x;
        longint hi_x;
        longint lo_y;
        longint hi_y;
    } bounds_t;

    pushout_t pushout_q[$];
    int       result_idx = 0;

    initial begin
        fail_count    = 0;
        pending_count = 0;
    end

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic box_t unpack_box(input logic [BOX_BITS-1:0] bits);
        box_t b;
        b.x      = bits[0 +: COORD_W];
        b.y      = bits[COORD_W +: COORD_W];
        b.width  = bits[2*COORD_W +: SIZE_W];
        b.height = bits[2*COORD_W + SIZE_W +: SIZE_W];
        b.cs     = bits[2*COORD_W + 2*SIZE_W +: ROT_W];
        b.sn     = bits[2*COORD_W + 2*SIZE_W + ROT_W +: ROT_W];
        return b;
    endfunction

    // world-axis interval of a rotated box, in fine units
    function automatic bounds_t box_bounds(input box_t b);
        longint  c, s, w, h, cx, cy, ex, ey;
        bounds_t r;
        c  = magnitude(longint'($signed(b.cs)));
        s  = magnitude(longint'($signed(b.sn)));
        w  = longint'(b.width);
        h  = longint'(b.height);
        cx = longint'($signed(b.x)) * FINE_ONE;
        cy = longint'($signed(b.y)) * FINE_ONE;
        ex = c*w + s*h;
        ey = s*w + c*h;
        r.lo_x = cx - ex;
        r.hi_x = cx + ex;
        r.lo_y = cy - ey;
        r.hi_y = cy + ey;
        return r;
    endfunction

    // to q16.16, nearest with ties away from zero
    function automatic longint round_to_coord(input longint p);
        longint m;
        m = (magnitude(p) + (FINE_ONE >>> 1)) >>> FINE_SHIFT;
        return (p < 0) ? -m : m;
    endfunction

    function automatic pushout_t predict_pushout(input logic [S_TDATA_W-1:0] word);
        bounds_t   mb, bb;
        longint    pen [4];
        longint    best;
        push_dir_t pick;
        pushout_t  r;
        mb = box_bounds(unpack_box(word[0 +: BOX_BITS]));
        bb = box_bounds(unpack_box(word[BOX_BITS +: BOX_BITS]));
        r.overlap = 1'b0;
        r.shift_x = '0;
        r.shift_y = '0;
        if (bb.lo_x > mb.hi_x || mb.lo_x > bb.hi_x || bb.lo_y > mb.hi_y || mb.lo_y > bb.hi_y)
            return r;
        pen[PUSH_NEG_X] = bb.lo_x - mb.hi_x;
        pen[PUSH_POS_X] = bb.hi_x - mb.lo_x;
        pen[PUSH_NEG_Y] = bb.lo_y - mb.hi_y;
        pen[PUSH_POS_Y] = bb.hi_y - mb.lo_y;
        pick = PUSH_NEG_X;
        best = magnitude(pen[PUSH_NEG_X]);
        for (int i = PUSH_POS_X; i <= PUSH_POS_Y; i++) begin
            if (magnitude(pen[i]) < best) begin
                best = magnitude(pen[i]);
                pick = push_dir_t'(i);
            end
        end
        r.overlap = 1'b1;
        if (pick == PUSH_NEG_X || pick == PUSH_POS_X)
            r.shift_x = SHIFT_W'(round_to_coord(pen[pick]));
        else
            r.shift_y = SHIFT_W'(round_to_coord(pen[pick]));
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("result %0d: %s got 0x%0h, expected 0x%0h", result_idx, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        pushout_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.overlap = m_tuser[0];
                got.shift_x = m_tdata[0 +: SHIFT_W];
                got.shift_y = m_tdata[SHIFT_W +: SHIFT_W];
                if (pushout_q.size() == 0) begin
                    report_mismatch("result with no request outstanding", got.overlap, 0);
                end else begin
                    want = pushout_q.pop_front();
                    if (got.overlap !== want.overlap)
                        report_mismatch("overlap", got.overlap, want.overlap);
                    if (got.shift_x !== want.shift_x)
                        report_mismatch("shift_x", got.shift_x, want.shift_x);
                    if (got.shift_y !== want.shift_y)
                        report_mismatch("shift_y", got.shift_y, want.shift_y);
                end
                result_idx++;
            end
            if (s_tvalid && s_tready)
                pushout_q.insert(pushout_q.size(), predict_pushout(s_tdata));
            pending_count = pushout_q.size();
        end
    end

endmodule

>>> verif/tb_top.sv
module tb_top;
    import bpop_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 10;
    localparam int TIMEOUT_CYCLES  = 200000;
    localparam int DRAIN_CYCLES    = 2*NUM_STAGES + 4;
    localparam int HOLD_CYCLES     = 60;
    localparam int NUM_PHASES      = 3;
    localparam int ITEMS_PER_PHASE = 367;
    localparam int BOX_BITS        = 2*COORD_W + 2*SIZE_W + 2*ROT_W;

    // q16.16 unit and half unit, q1.14 unity
    localparam int UNIT = 1 << 16;
    localparam int HALF = UNIT / 2;
    localparam int ONE  = 1 << ROT_FRAC_BITS;

    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [SIZE_W-1:0]         SIZE_MAX  = '1;
    localparam logic signed [ROT_W-1:0]   ROT_MIN   = {1'b1, {(ROT_W-1){1'b0}}};
    localparam logic signed [ROT_W-1:0]   ROT_MAX   = {1'b0, {(ROT_W-1){1'b1}}};

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    int fail_count;
    int pending_count;

    // idle odds in percent for each side
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    // long result hold-off, asked for by the stimulus and timed by the receiver
    logic hold_req  = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;

    always #(CLK_PERIOD/2) aclk = ~aclk;

    box_pair_overlap_pushout_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    box_pair_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    function automatic box_t make_box(input logic signed [COORD_W-1:0] x,
                                      input logic signed [COORD_W-1:0] y,
                                      input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                                      input logic signed [ROT_W-1:0] cs,
                                      input logic signed [ROT_W-1:0] sn);
        box_t b;
        b.x      = x;
        b.y      = y;
        b.width  = w;
        b.height = h;
        b.cs     = cs;
        b.sn     = sn;
        return b;
    endfunction

    // tdata order is x lowest, sin highest
    function automatic logic [BOX_BITS-1:0] pack_box(input box_t b);
        return {b.sn, b.cs, b.height, b.width, b.y, b.x};
    endfunction

    // mostly unit-ish rotations, sometimes the code extremes or any pattern at all
    function automatic logic signed [ROT_W-1:0] rand_rot();
        int k;
        k = $urandom_range(19);
        if (k < 2)
            return ROT_W'($urandom);
        if (k < 5) begin
            case ($urandom_range(4))
                0:       return ROT_MIN;
                1:       return ROT_MAX;
                2:       return ROT_W'(ONE);
                3:       return ROT_W'(-ONE);
                default: return '0;
            endcase
        end
        return ROT_W'(int'($urandom_range(2*ONE)) - ONE);
    endfunction

    // axis-aligned or quarter-turned box with sizes on a unit grid, odd by one lsb
    // now and then, so touching, equal penetrations and rounding ties turn up often
    function automatic box_t grid_box(input logic signed [COORD_W-1:0] x,
                                      input logic signed [COORD_W-1:0] y);
        logic signed [ROT_W-1:0] cs, sn;
        logic [SIZE_W-1:0]       w, h;
        case ($urandom_range(3))
            0:       begin cs = ROT_W'(ONE);  sn = '0;           end
            1:       begin cs = ROT_W'(-ONE); sn = '0;           end
            2:       begin cs = '0;           sn = ROT_W'(ONE);  end
            default: begin cs = '0;           sn = ROT_W'(-ONE); end
        endcase
        w = SIZE_W'(UNIT * $urandom_range(8) + ($urandom_range(3) == 0));
        h = SIZE_W'(UNIT * $urandom_range(8) + ($urandom_range(3) == 0));
        return make_box(x, y, w, h, cs, sn);
    endfunction

    function automatic void rand_pair(output box_t mover, output box_t block);
        int k;
        int offs_x, offs_y;
        k = $urandom_range(99);
        block.x = COORD_W'($urandom);
        block.y = COORD_W'($urandom);
        if (k < 30) begin
            // grid pairs, a few half units apart
            block.x &= ~COORD_W'(HALF - 1);
            block.y &= ~COORD_W'(HALF - 1);
            offs_x = HALF * (int'($urandom_range(24)) - 12);
            offs_y = HALF * (int'($urandom_range(24)) - 12);
            block  = grid_box(block.x, block.y);
            mover  = grid_box(block.x + COORD_W'(offs_x), block.y + COORD_W'(offs_y));
        end else if (k < 70) begin
            // rotated neighbours, usually touching or overlapping
            offs_x = int'($urandom_range(1 << 23)) - (1 << 22);
            offs_y = int'($urandom_range(1 << 23)) - (1 << 22);
            block  = make_box(block.x, block.y, SIZE_W'($urandom_range(1 << 22)),
                              SIZE_W'($urandom_range(1 << 22)), rand_rot(), rand_rot());
            mover  = make_box(block.x + COORD_W'(offs_x), block.y + COORD_W'(offs_y),
                              SIZE_W'($urandom_range(1 << 22)), SIZE_W'($urandom_range(1 << 22)),
                              rand_rot(), rand_rot());
        end else if (k < 85) begin
            // any bit pattern in every field
            block = make_box(block.x, block.y, SIZE_W'($urandom), SIZE_W'($urandom),
                             ROT_W'($urandom), ROT_W'($urandom));
            mover = make_box(COORD_W'($urandom), COORD_W'($urandom), SIZE_W'($urandom),
                             SIZE_W'($urandom), ROT_W'($urandom), ROT_W'($urandom));
        end else begin
            // huge boxes, where shifts may run past the result width and wrap
            block = make_box(block.x, block.y, SIZE_W'($urandom) | SIZE_W'(1 << 30),
                             SIZE_W'($urandom) | SIZE_W'(1 << 30), rand_rot(), rand_rot());
            mover = make_box(COORD_W'($urandom), COORD_W'($urandom),
                             SIZE_W'($urandom) | SIZE_W'(1 << 30),
                             SIZE_W'($urandom) | SIZE_W'(1 << 30), rand_rot(), rand_rot());
        end
    endfunction

    // offer one request from a falling edge, idling first at the sender's odds; returns on
    // the falling edge after acceptance with s_tvalid still high for back-to-back requests
    task automatic send_pair(input box_t mover, input box_t block);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({pack_box(block), pack_box(mover)});
        do
            @(posedge aclk);
        while (!s_tready);
        @(negedge aclk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_count != 0)
            @(negedge aclk);
    endtask

    // receiver: random stalls, plus one long hold-off so the pipe fills and s_tready drops
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_tready  <= 1'b0;
            hold_left = HOLD_CYCLES - 1;
            hold_done = 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // watchdog
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        box_t mover, block;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        aresetn  = 1'b0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // zero-sized boxes on one centre touch everywhere
        send_pair(make_box(0, 0, 0, 0, 0, 0), make_box(0, 0, 0, 0, 0, 0));
        // one lsb apart on x, then just touching on x, then apart on y
        send_pair(make_box(0, 0, 2*UNIT, 2*UNIT, ONE, 0),
                  make_box(2*UNIT + 1, 0, 2*UNIT, 2*UNIT, ONE, 0));
        send_pair(make_box(0, 0, 2*UNIT, 2*UNIT, ONE, 0),
                  make_box(2*UNIT, 0, 2*UNIT, 2*UNIT, ONE, 0));
        send_pair(make_box(0, 0, 2*UNIT, 2*UNIT, ONE, 0),
                  make_box(0, -2*UNIT - 1, 2*UNIT, 2*UNIT, ONE, 0));
        // one push in each direction
        send_pair(make_box(0, 0, 2*UNIT, 2*UNIT, ONE, 0),
                  make_box(UNIT, 0, 2*UNIT, 2*UNIT, ONE, 0));
        send_pair(make_box(0, 0, 2*UNIT, 2*UNIT, ONE, 0),
                  make_box(-UNIT, 0, 2*UNIT, 2*UNIT, ONE, 0));
        send_pair(make_box(0, 0, 2*UNIT, 2*UNIT, ONE, 0),
                  make_box(0, UNIT, 2*UNIT, 2*UNIT, ONE, 0));
        send_pair(make_box(0, 0, 2*UNIT, 2*UNIT, ONE, 0),
                  make_box(0, -UNIT, 2*UNIT, 2*UNIT, ONE, 0));
        // equal penetrations: the earlier direction has to win
        send_pair(make_box(0, 0, 2*UNIT, 4*UNIT, ONE, 0),
                  make_box(0, 0, 2*UNIT, 4*UNIT, ONE, 0));
        send_pair(make_box(0, 0, 2*UNIT, 2*UNIT, ONE, 0),
                  make_box(HALF, HALF, 2*UNIT, 2*UNIT, ONE, 0));
        send_pair(make_box(0, 0, 2*UNIT, 2*UNIT, ONE, 0),
                  make_box(-HALF, HALF, 2*UNIT, 2*UNIT, ONE, 0));
        send_pair(make_box(0, 0, 2*UNIT, 2*UNIT, ONE, 0),
                  make_box(-HALF, -HALF, 2*UNIT, 2*UNIT, ONE, 0));
        send_pair(make_box(0, 0, 4*UNIT, 2*UNIT, ONE, 0),
                  make_box(0, 0, 4*UNIT, 2*UNIT, ONE, 0));
        // a half-lsb penetration, rounded away from zero, then a pair half an lsb apart
        send_pair(make_box(0, 0, 1, 4*UNIT, ONE, 0), make_box(0, 0, 0, 4*UNIT, ONE, 0));
        send_pair(make_box(0, 0, 1, 4*UNIT, ONE, 0), make_box(1, 0, 0, 4*UNIT, ONE, 0));
        // quarter turn swaps the extents
        send_pair(make_box(0, 0, 4*UNIT, 2*UNIT, 0, ONE),
                  make_box(UNIT, 0, 2*UNIT, 2*UNIT, ONE, 0));
        // rotation codes beyond unity, largest sizes, shifts that wrap
        send_pair(make_box(0, 0, SIZE_MAX, SIZE_MAX, ROT_MIN, ROT_MIN),
                  make_box(0, 0, SIZE_MAX, SIZE_MAX, ROT_MIN, ROT_MIN));
        send_pair(make_box(COORD_MIN, COORD_MAX, SIZE_MAX, SIZE_MAX, ROT_MIN, ROT_MAX),
                  make_box(COORD_MAX, COORD_MIN, SIZE_MAX, SIZE_MAX, ROT_MAX, ROT_MIN));
        send_pair(make_box(COORD_MAX, COORD_MAX, SIZE_MAX, 0, ROT_MAX, ROT_MAX),
                  make_box(COORD_MAX, COORD_MAX, 0, SIZE_MAX, -ONE, -ONE));
        send_pair(make_box(COORD_MIN, COORD_MIN, 0, 0, ONE, 0),
                  make_box(COORD_MIN, COORD_MIN, 0, 0, ONE, 0));
        // opposite ends of the coordinate range, far apart
        send_pair(make_box(COORD_MIN, 0, 0, 0, ONE, 0), make_box(COORD_MAX, 0, 0, 0, ONE, 0));
        // alternating bit patterns
        send_pair(make_box(32'h5555_5555, 32'hAAAA_AAAA, 31'h2AAA_AAAA, 31'h5555_5555,
                           16'h5555, 16'hAAAA),
                  make_box(32'hAAAA_AAAA, 32'h5555_5555, 31'h5555_5555, 31'h2AAA_AAAA,
                           16'hAAAA, 16'h5555));
        wait_idle();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 12;
                    rx_idle_pct <= 64;
                end
                1: begin
                    tx_idle_pct = 64;
                    rx_idle_pct <= 12;
                end
                default: begin
                    // no idling; the receiver holds off for a while so the pipe backs up
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                    hold_req    <= 1'b1;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                rand_pair(mover, block);
                send_pair(mover, block);
            end
            // sender pauses until the pipe has emptied
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
